// ----- hdl/itrt_pkg.sv -----
package itrt_pkg;

  localparam int unsigned CFG_W       = 6;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIV_STEP_BITS = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_RADIX = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD   = 1'd1;

  localparam logic [CFG_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [CFG_W-1:0] PAD_RESET   = 6'd0;
  localparam logic [CFG_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [CFG_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS      = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 7'h5F;
  localparam logic [CHAR_W-1:0] DECIMAL_DIGITS  = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEN,
    ST_PAD,
    ST_SIGN,
    ST_RD,
    ST_DIG
  } state_e;

  typedef struct packed {
    logic done;
    logic zero;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (dx < DECIMAL_DIGITS) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_UPPER_A + (dx - DECIMAL_DIGITS);
    end
  endfunction

endpackage

// ----- hdl/int_to_radix_text_padded.sv -----
// Channel   Direction  Contents
// s_*       in         tdata: value (VALUE_BITS, two's complement), zero-filled to bytes
// m_*       out        tdata: text_char (7 bits); tlast: last character of the number
// cfg_*     in         write enable, register index (0 radix, 1 pad width), 6-bit data
//
// Each digit comes from the shared divider, which retires four quotient bits per cycle.
// Pad underscores and the sign are emitted directly; each digit is first read back
// through the registered port of the digit RAM.
// s_tready is high only while the sequencer is idle; a stalled m_tready holds
// the sequencer. Reset sets radix to 10 and pad width to 0; the digit RAM is not cleared.
module int_to_radix_text_padded #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_TEXT   = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // [VALUE_BITS-1:0] value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [6:0] text_char
  output logic                              m_tlast,
  input  logic                              cfg_we_i,
  input  logic [itrt_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [itrt_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int DIGIT_DEPTH = VALUE_BITS + 1;
  localparam int AW          = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(VALUE_BITS + MAX_TEXT + 2);

  itrt_pkg::state_e              state_q, state_d;
  itrt_pkg::div_status_t         div_stat;

  logic [itrt_pkg::CFG_W-1:0]    radix_q, pad_width_q;
  logic [itrt_pkg::DIGIT_W-1:0]  base_q, base_d;
  logic [CNT_W-1:0]              pad_q, pad_d;
  logic                          neg_q, neg_d;
  logic [CNT_W-1:0]              ndig_q, ndig_d;
  logic [CNT_W-1:0]              pads_q, pads_d;
  logic [CNT_W-1:0]              left_q, left_d;
  logic [AW-1:0]                 dig_idx_q, dig_idx_d;
  logic                          m_valid_q, m_valid_d;
  logic [itrt_pkg::CHAR_W-1:0]   m_char_q, m_char_d;
  logic                          m_last_q, m_last_d;

  logic [VALUE_BITS-1:0]         in_value, in_mag;
  logic [itrt_pkg::DIGIT_W-1:0]  base_eff;
  logic [CNT_W-1:0]              pad_eff, len, total;
  logic                          accept, out_free, out_load, last_char;
  logic                          div_start;
  logic [VALUE_BITS-1:0]         div_dividend, div_quot;
  logic [itrt_pkg::DIGIT_W-1:0]  div_divisor;
  logic [itrt_pkg::DIGIT_W-1:0]  div_rem, ram_rdata;
  logic                          ram_we;

  assign in_value = s_tdata[VALUE_BITS-1:0];
  assign in_mag   = in_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - in_value) : in_value;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state_q == itrt_pkg::ST_IDLE);
  assign out_free = !m_valid_q || m_tready;
  assign last_char = (left_q == CNT_W'(1));

  always_comb begin
    if (radix_q < itrt_pkg::RADIX_MIN) begin
      base_eff = itrt_pkg::RADIX_MIN;
    end else if (radix_q > itrt_pkg::RADIX_MAX) begin
      base_eff = itrt_pkg::RADIX_MAX;
    end else begin
      base_eff = radix_q;
    end
    if (CNT_W'(pad_width_q) > CNT_W'(MAX_TEXT)) begin
      pad_eff = CNT_W'(MAX_TEXT);
    end else begin
      pad_eff = CNT_W'(pad_width_q);
    end
  end

  assign len   = ndig_q + CNT_W'(neg_q);
  assign total = (len < pad_q) ? pad_q : len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= itrt_pkg::RADIX_RESET;
      pad_width_q <= itrt_pkg::PAD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == itrt_pkg::REG_RADIX) begin
        radix_q <= cfg_data_i;
      end
      if (cfg_addr_i == itrt_pkg::REG_PAD) begin
        pad_width_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      itrt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = itrt_pkg::ST_DIV;
        end
      end
      itrt_pkg::ST_DIV: begin
        if (div_stat.done && div_stat.zero) begin
          state_d = itrt_pkg::ST_LEN;
        end
      end
      itrt_pkg::ST_LEN: begin
        if (total != len) begin
          state_d = itrt_pkg::ST_PAD;
        end else if (neg_q) begin
          state_d = itrt_pkg::ST_SIGN;
        end else begin
          state_d = itrt_pkg::ST_RD;
        end
      end
      itrt_pkg::ST_PAD: begin
        if (out_free && pads_q == CNT_W'(1)) begin
          state_d = neg_q ? itrt_pkg::ST_SIGN : itrt_pkg::ST_RD;
        end
      end
      itrt_pkg::ST_SIGN, itrt_pkg::ST_DIG: begin
        if (out_free) begin
          state_d = last_char ? itrt_pkg::ST_IDLE : itrt_pkg::ST_RD;
        end
      end
      itrt_pkg::ST_RD: begin
        state_d = itrt_pkg::ST_DIG;
      end
      default: begin
        state_d = itrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    base_d       = base_q;
    pad_d        = pad_q;
    neg_d        = neg_q;
    ndig_d       = ndig_q;
    pads_d       = pads_q;
    left_d       = left_q;
    dig_idx_d    = dig_idx_q;
    m_char_d     = m_char_q;
    m_last_d     = m_last_q;
    m_valid_d    = m_valid_q && !m_tready;
    div_start    = 1'b0;
    div_dividend = div_quot;
    ram_we       = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      itrt_pkg::ST_IDLE: begin
        if (accept) begin
          base_d       = base_eff;
          pad_d        = pad_eff;
          neg_d        = in_value[VALUE_BITS-1];
          ndig_d       = '0;
          div_start    = 1'b1;
          div_dividend = in_mag;
        end
      end
      itrt_pkg::ST_DIV: begin
        if (div_stat.done) begin
          ram_we    = 1'b1;
          ndig_d    = ndig_q + CNT_W'(1);
          div_start = !div_stat.zero;
        end
      end
      itrt_pkg::ST_LEN: begin
        pads_d    = total - len;
        left_d    = (total > CNT_W'(MAX_TEXT)) ? CNT_W'(MAX_TEXT) : total;
        dig_idx_d = AW'(ndig_q - CNT_W'(1));
      end
      itrt_pkg::ST_PAD: begin
        if (out_free) begin
          out_load = 1'b1;
          m_char_d = itrt_pkg::CHAR_UNDERSCORE;
          pads_d   = pads_q - CNT_W'(1);
        end
      end
      itrt_pkg::ST_SIGN: begin
        if (out_free) begin
          out_load = 1'b1;
          m_char_d = itrt_pkg::CHAR_MINUS;
        end
      end
      itrt_pkg::ST_DIG: begin
        if (out_free) begin
          out_load  = 1'b1;
          m_char_d  = itrt_pkg::digit_char(ram_rdata);
          dig_idx_d = dig_idx_q - AW'(1);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_valid_d = 1'b1;
      m_last_d  = last_char;
      left_d    = left_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= itrt_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      ndig_q    <= '0;
      left_q    <= '0;
      pads_q    <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      ndig_q    <= ndig_d;
      left_q    <= left_d;
      pads_q    <= pads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    pad_q     <= pad_d;
    neg_q     <= neg_d;
    dig_idx_q <= dig_idx_d;
    m_char_q  <= m_char_d;
    m_last_q  <= m_last_d;
  end

  assign div_divisor = (state_q == itrt_pkg::ST_IDLE) ? base_eff : base_q;

  itrt_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .status_o    (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  itrt_ram #(
    .WIDTH (itrt_pkg::DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ndig_q[AW-1:0]),
    .wdata_i (div_rem),
    .raddr_i (dig_idx_q),
    .rdata_o (ram_rdata)
  );

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {1'b0, m_char_q};
  assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == itrt_pkg::ST_DIV))
    else $error("divider finished outside of the division phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= CNT_W'(VALUE_BITS))
    else $error("digit count exceeds the digit store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itrt_pkg::ST_PAD || state_q == itrt_pkg::ST_SIGN ||
     state_q == itrt_pkg::ST_RD || state_q == itrt_pkg::ST_DIG) |-> (left_q != '0))
    else $error("emission phase with no characters left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_char) |=> (state_q == itrt_pkg::ST_IDLE))
    else $error("last character sent but sequencer did not return to idle");
`endif

endmodule

// ----- hdl/itrt_ram.sv -----
module itrt_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/itrt_divider.sv -----
module itrt_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [VALUE_BITS-1:0]        dividend_i,
  input  logic [itrt_pkg::DIGIT_W-1:0] divisor_i,
  output itrt_pkg::div_status_t        status_o,
  output logic [VALUE_BITS-1:0]        quotient_o,
  output logic [itrt_pkg::DIGIT_W-1:0] remainder_o
);

  localparam int STEP  = itrt_pkg::DIV_STEP_BITS;
  localparam int DIV_W = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int STEPS = DIV_W / STEP;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int RW    = itrt_pkg::DIGIT_W + 1;

  logic [DIV_W-1:0]              quot_q, step_quot;
  logic [itrt_pkg::DIGIT_W-1:0]  rem_q, div_q;
  logic [RW-1:0]                 step_rem;
  logic [CW-1:0]                 cnt_q;
  logic                          done_q;

  // Restoring division, STEP quotient bits per cycle.
  always_comb begin
    step_rem  = {1'b0, rem_q};
    step_quot = quot_q;
    for (int i = 0; i < STEP; i++) begin
      step_rem  = {step_rem[RW-2:0], step_quot[DIV_W-1]};
      step_quot = {step_quot[DIV_W-2:0], 1'b0};
      if (step_rem >= {1'b0, div_q}) begin
        step_rem     = step_rem - {1'b0, div_q};
        step_quot[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= DIV_W'(dividend_i);
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= step_quot;
      rem_q  <= step_rem[itrt_pkg::DIGIT_W-1:0];
    end
  end

  assign status_o.done = done_q;
  assign status_o.zero = (quot_q == '0);
  assign quotient_o    = quot_q[VALUE_BITS-1:0];
  assign remainder_o   = rem_q;

endmodule
